/* rtl/prfg_pkg.sv */
// Shared types, constants and register codes for the pseudo-random frame generator.
// No dependencies; imported by every module of the block.
package prfg_pkg;

   // dimension limit and queue sizing
   localparam int unsigned MAX_DIMENSION = 8192;
   localparam int unsigned QUEUE_DEPTH   = 2;

   // field widths
   localparam int unsigned DIM_W         = 14;
   localparam int unsigned FORMAT_W      = 4;
   localparam int unsigned PERIOD_W      = 30;
   localparam int unsigned WORD_W        = 32;
   localparam int unsigned PROD_W        = 27;
   localparam int unsigned PLANE_BYTES_W = 28;
   localparam int unsigned STRIDE_W      = 15;
   localparam int unsigned CSR_INDEX_W   = 3;
   localparam int unsigned CSR_DATA_W    = 32;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_FORMAT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MULTI_PLANE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEED         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_NS    = 3'd5;

   // pixel format codes, anything above grey is unknown
   localparam logic [FORMAT_W-1:0] FMT_MJPEG = 4'd0;
   localparam logic [FORMAT_W-1:0] FMT_H264  = 4'd1;
   localparam logic [FORMAT_W-1:0] FMT_YUYV  = 4'd2;
   localparam logic [FORMAT_W-1:0] FMT_UYVY  = 4'd3;
   localparam logic [FORMAT_W-1:0] FMT_RGB24 = 4'd4;
   localparam logic [FORMAT_W-1:0] FMT_BGR24 = 4'd5;
   localparam logic [FORMAT_W-1:0] FMT_NV12  = 4'd6;
   localparam logic [FORMAT_W-1:0] FMT_GREY  = 4'd7;

   // register reset values
   localparam logic [DIM_W-1:0]    RESET_WIDTH  = 14'd640;
   localparam logic [DIM_W-1:0]    RESET_HEIGHT = 14'd480;
   localparam logic [FORMAT_W-1:0] RESET_FORMAT = FMT_GREY;
   localparam logic [PERIOD_W-1:0] RESET_PERIOD = 30'd33333333;

   // generator and timestamp constants
   localparam logic [WORD_W-1:0] LCG_MULT      = 32'd1664525;
   localparam logic [WORD_W-1:0] LCG_INC       = 32'd1013904223;
   localparam logic [WORD_W-1:0] NS_PER_SECOND = 32'd1000000000;
   localparam logic [PLANE_BYTES_W-1:0] MIN_COMPRESSED_BYTES = 28'd64;
   localparam int unsigned BYTE_SHIFT = 24;

   // frame layout and timing, derived from the registers
   typedef struct packed {
      logic                     supported;
      logic                     two_planes;
      logic [PLANE_BYTES_W-1:0] len0;
      logic [PLANE_BYTES_W-1:0] len0_last;
      logic [PLANE_BYTES_W-1:0] len1;
      logic [PLANE_BYTES_W-1:0] len1_last;
      logic [STRIDE_W-1:0]      stride;
      logic [WORD_W-1:0]        seed;
      logic [WORD_W-1:0]        period;
      logic [WORD_W-1:0]        period_less1;
      logic [WORD_W-1:0]        period_less2;
   } layout_type;

endpackage

/* rtl/prfg_front.sv */
// Front end: configuration registers, frame layout decode and the input stage.
// Depends on prfg_pkg.
module prfg_front import prfg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_restart,
   output logic                   push_valid,
   input  logic                   push_ready,
   output logic                   push_restart,
   output layout_type             layout
);

   logic [DIM_W-1:0]    width_ff;
   logic [DIM_W-1:0]    height_ff;
   logic [FORMAT_W-1:0] format_ff;
   logic                multi_ff;
   logic [WORD_W-1:0]   seed_ff;
   logic [PERIOD_W-1:0] period_ff;

   logic [DIM_W-1:0]    width_clamp;
   logic [DIM_W-1:0]    height_clamp;
   logic [PROD_W-1:0]   pixels_in;
   logic [PROD_W-1:0]   pixels_ff;
   logic [DIM_W-1:0]    width_cl_ff;

   logic [PLANE_BYTES_W-1:0] p;
   logic [PLANE_BYTES_W-1:0] p_twice;
   logic [PLANE_BYTES_W-1:0] p_eighth;
   logic [PLANE_BYTES_W-1:0] p_half_dn;
   logic [PLANE_BYTES_W-1:0] p_odd;
   logic [STRIDE_W-1:0]      w;
   layout_type               layout_in;
   layout_type               layout_ff;

   logic item_valid_ff;
   logic item_restart_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         format_ff <= RESET_FORMAT;
         multi_ff  <= 1'b0;
         seed_ff   <= '0;
         period_ff <= RESET_PERIOD;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_write_data[DIM_W-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_write_data[DIM_W-1:0];
            CSR_PIXEL_FORMAT: format_ff <= csr_write_data[FORMAT_W-1:0];
            CSR_MULTI_PLANE:  multi_ff  <= csr_write_data[0];
            CSR_SEED:         seed_ff   <= csr_write_data[WORD_W-1:0];
            CSR_PERIOD_NS:    period_ff <= csr_write_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp dimensions and form the pixel count
   always_comb begin
      if (width_ff == '0)
         width_clamp = DIM_W'(1);
      else if (width_ff > DIM_W'(MAX_DIMENSION))
         width_clamp = DIM_W'(MAX_DIMENSION);
      else
         width_clamp = width_ff;
      if (height_ff == '0)
         height_clamp = DIM_W'(1);
      else if (height_ff > DIM_W'(MAX_DIMENSION))
         height_clamp = DIM_W'(MAX_DIMENSION);
      else
         height_clamp = height_ff;
      pixels_in = PROD_W'(width_clamp) * PROD_W'(height_clamp);
   end

   always_ff @(posedge clock) begin
      pixels_ff   <= pixels_in;
      width_cl_ff <= width_clamp;
   end

   // plane lengths and stride per format, with last byte index of each plane
   always_comb begin
      p         = PLANE_BYTES_W'(pixels_ff);
      p_twice   = {p[PLANE_BYTES_W-2:0], 1'b0};
      p_eighth  = p >> 3;
      p_half_dn = p >> 1;
      p_odd     = PLANE_BYTES_W'(p[0]);
      w         = STRIDE_W'(width_cl_ff);

      layout_in              = '0;
      layout_in.supported    = 1'b1;
      layout_in.seed         = seed_ff;
      layout_in.period       = WORD_W'(period_ff);
      layout_in.period_less1 = WORD_W'(period_ff) - NS_PER_SECOND;
      layout_in.period_less2 = WORD_W'(period_ff) - {NS_PER_SECOND[WORD_W-2:0], 1'b0};

      case (format_ff)
         FMT_MJPEG, FMT_H264: begin
            if (p_eighth > MIN_COMPRESSED_BYTES) begin
               layout_in.len0      = p_eighth;
               layout_in.len0_last = p_eighth - PLANE_BYTES_W'(1);
            end else begin
               layout_in.len0      = MIN_COMPRESSED_BYTES;
               layout_in.len0_last = MIN_COMPRESSED_BYTES - PLANE_BYTES_W'(1);
            end
         end
         FMT_YUYV, FMT_UYVY: begin
            layout_in.len0      = p_twice;
            layout_in.len0_last = p_twice - PLANE_BYTES_W'(1);
            layout_in.stride    = {w[STRIDE_W-2:0], 1'b0};
         end
         FMT_RGB24, FMT_BGR24: begin
            layout_in.len0      = p + p_twice;
            layout_in.len0_last = p + p_twice - PLANE_BYTES_W'(1);
            layout_in.stride    = w + {w[STRIDE_W-2:0], 1'b0};
         end
         FMT_NV12: begin
            layout_in.stride = w;
            if (multi_ff) begin
               layout_in.two_planes = 1'b1;
               layout_in.len0       = p;
               layout_in.len0_last  = p - PLANE_BYTES_W'(1);
               layout_in.len1       = p_half_dn + p_odd;
               layout_in.len1_last  = p[0] ? p_half_dn : p_half_dn - PLANE_BYTES_W'(1);
            end else begin
               layout_in.len0      = p + p_half_dn + p_odd;
               layout_in.len0_last = p[0] ? p + p_half_dn
                                          : p + p_half_dn - PLANE_BYTES_W'(1);
            end
         end
         FMT_GREY: begin
            layout_in.len0      = p;
            layout_in.len0_last = p - PLANE_BYTES_W'(1);
            layout_in.stride    = w;
         end
         default: layout_in.supported = 1'b0;
      endcase

      // multi-plane is only defined for nv12
      if (multi_ff && (format_ff != FMT_NV12))
         layout_in.supported = 1'b0;
   end

   always_ff @(posedge clock) begin
      layout_ff <= layout_in;
   end

   assign layout = layout_ff;

   // input stage, one item deep, drains into the queue
   assign req_ready    = !item_valid_ff || push_ready;
   assign push_valid   = item_valid_ff;
   assign push_restart = item_restart_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         item_valid_ff <= 1'b1;
      end else if (push_ready) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready)
         item_restart_ff <= req_restart;
   end

endmodule

/* rtl/prfg_queue.sv */
// Short item queue between front end and generator back end.
// Depends on prfg_pkg for the default depth, QUEUE_DEPTH.
module prfg_queue import prfg_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  logic push_restart,
   output logic pop_valid,
   input  logic pop_ready,
   output logic pop_restart
);

   localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

   logic [DEPTH-1:0]   slot_ff;
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               push_xfer;
   logic               pop_xfer;

   assign push_ready  = (count_ff != COUNT_W'(DEPTH));
   assign pop_valid   = (count_ff != '0);
   assign pop_restart = slot_ff[rd_ptr_ff];
   assign push_xfer   = push_valid && push_ready;
   assign pop_xfer    = pop_valid && pop_ready;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_xfer)
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         if (pop_xfer)
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         if (push_xfer && !pop_xfer)
            count_ff <= count_ff + COUNT_W'(1);
         else if (pop_xfer && !push_xfer)
            count_ff <= count_ff - COUNT_W'(1);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push_xfer)
         slot_ff[wr_ptr_ff] <= push_restart;
   end

endmodule

/* rtl/prfg_back.sv */
// Back end: generator state, frame position, sequence and timestamp, result register.
// Depends on prfg_pkg for the layout struct and constants.
module prfg_back import prfg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  layout_type               layout,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  logic                     pop_restart,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_data_byte,
   output logic                     rsp_plane_index,
   output logic [PLANE_BYTES_W-1:0] rsp_plane_bytes,
   output logic [STRIDE_W-1:0]      rsp_line_stride,
   output logic                     rsp_last_in_plane,
   output logic                     rsp_last_in_frame,
   output logic [WORD_W-1:0]        rsp_frame_number,
   output logic [WORD_W-1:0]        rsp_stamp_seconds,
   output logic [PERIOD_W-1:0]      rsp_stamp_nanoseconds,
   output logic                     rsp_status
);

   logic [WORD_W-1:0]        gen_ff, gen_in;
   logic [PLANE_BYTES_W-1:0] pos_ff, pos_in;
   logic                     plane_ff, plane_in;
   logic [WORD_W-1:0]        seq_ff, seq_in;
   logic [WORD_W-1:0]        sec_ff, sec_in;
   logic [PERIOD_W-1:0]      ns_ff, ns_in;
   logic                     active_ff, active_in;
   logic                     rsp_valid_ff;

   logic                     take;
   logic [WORD_W-1:0]        seq_base;
   logic [WORD_W-1:0]        sec_base;
   logic [PERIOD_W-1:0]      ns_base;
   logic                     active_base;
   logic [WORD_W-1:0]        gen_base;
   logic [WORD_W-1:0]        gen_new;
   logic [PLANE_BYTES_W-1:0] pos_base;
   logic                     plane_sel;
   logic [PLANE_BYTES_W-1:0] plane_len;
   logic [PLANE_BYTES_W-1:0] plane_last;
   logic                     last_plane;
   logic                     last_frame;
   logic [WORD_W-1:0]        ns_sum0;
   logic [WORD_W-1:0]        ns_sum1;
   logic [WORD_W-1:0]        ns_sum2;
   logic [PERIOD_W-1:0]      ns_next;
   logic [1:0]               sec_carry;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;

   // restart clears the counts before the item is looked at
   always_comb begin
      seq_base    = pop_restart ? '0 : seq_ff;
      sec_base    = pop_restart ? '0 : sec_ff;
      ns_base     = pop_restart ? '0 : ns_ff;
      active_base = !pop_restart && active_ff;
   end

   // generator step and plane position
   always_comb begin
      gen_base   = active_base ? gen_ff : (layout.seed ^ seq_base);
      gen_new    = gen_base * LCG_MULT + LCG_INC;
      pos_base   = active_base ? pos_ff : '0;
      plane_sel  = active_base && plane_ff && layout.two_planes;
      plane_len  = plane_sel ? layout.len1 : layout.len0;
      plane_last = plane_sel ? layout.len1_last : layout.len0_last;
      last_plane = (pos_base >= plane_last);
      last_frame = last_plane && (plane_sel || !layout.two_planes);
   end

   // timestamp advance, at most two whole seconds per frame
   always_comb begin
      ns_sum0 = WORD_W'(ns_base) + layout.period;
      ns_sum1 = WORD_W'(ns_base) + layout.period_less1;
      ns_sum2 = WORD_W'(ns_base) + layout.period_less2;
      if (!ns_sum2[WORD_W-1]) begin
         ns_next   = ns_sum2[PERIOD_W-1:0];
         sec_carry = 2'd2;
      end else if (!ns_sum1[WORD_W-1]) begin
         ns_next   = ns_sum1[PERIOD_W-1:0];
         sec_carry = 2'd1;
      end else begin
         ns_next   = ns_sum0[PERIOD_W-1:0];
         sec_carry = 2'd0;
      end
   end

   // next state
   always_comb begin
      gen_in    = gen_ff;
      pos_in    = pos_ff;
      plane_in  = plane_ff;
      seq_in    = seq_ff;
      sec_in    = sec_ff;
      ns_in     = ns_ff;
      active_in = active_ff;
      if (take) begin
         seq_in = seq_base;
         sec_in = sec_base;
         ns_in  = ns_base;
         if (!layout.supported) begin
            active_in = 1'b0;
         end else begin
            gen_in = gen_new;
            if (last_frame) begin
               active_in = 1'b0;
               pos_in    = '0;
               plane_in  = 1'b0;
               seq_in    = seq_base + WORD_W'(1);
               sec_in    = sec_base + WORD_W'(sec_carry);
               ns_in     = ns_next;
            end else if (last_plane) begin
               active_in = 1'b1;
               pos_in    = '0;
               plane_in  = 1'b1;
            end else begin
               active_in = 1'b1;
               pos_in    = pos_base + PLANE_BYTES_W'(1);
               plane_in  = plane_sel;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff    <= '0;
         pos_ff    <= '0;
         plane_ff  <= 1'b0;
         seq_ff    <= '0;
         sec_ff    <= '0;
         ns_ff     <= '0;
         active_ff <= 1'b0;
      end else begin
         gen_ff    <= gen_in;
         pos_ff    <= pos_in;
         plane_ff  <= plane_in;
         seq_ff    <= seq_in;
         sec_ff    <= sec_in;
         ns_ff     <= ns_in;
         active_ff <= active_in;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_frame_number      <= seq_base;
         rsp_stamp_seconds     <= sec_base;
         rsp_stamp_nanoseconds <= ns_base;
         if (layout.supported) begin
            rsp_data_byte     <= gen_new[BYTE_SHIFT +: 8];
            rsp_plane_index   <= plane_sel;
            rsp_plane_bytes   <= plane_len;
            rsp_line_stride   <= layout.stride;
            rsp_last_in_plane <= last_plane;
            rsp_last_in_frame <= last_frame;
            rsp_status        <= 1'b0;
         end else begin
            rsp_data_byte     <= '0;
            rsp_plane_index   <= 1'b0;
            rsp_plane_bytes   <= '0;
            rsp_line_stride   <= '0;
            rsp_last_in_plane <= 1'b0;
            rsp_last_in_frame <= 1'b0;
            rsp_status        <= 1'b1;
         end
      end
   end

endmodule

/* rtl/pseudo_random_frame_generator_core.sv */
// Top level of the pseudo-random frame generator: front end, item queue, back end.
// Depends on prfg_pkg, prfg_front, prfg_queue and prfg_back.
//
//   channel   direction  handshake          payload
//   req       in         req_valid/ready    req_restart
//   rsp       out        rsp_valid/ready    byte, plane, lengths, last flags, stamps, status
//   csr       in         csr_write_enable   csr_index, csr_write_data
//
// One byte per clock sustained while rsp is ready; the back end takes one queued item per
// cycle through its single generator multiply-add, which also carries the frame state loop.
// An item passes from req through the input stage and the queue into the result register.
// Synchronous reset clears control state and loads register defaults; no clearing pass.
// A stalled rsp holds the result register; the queue and input stage then fill and
// req_ready drops.
module pseudo_random_frame_generator_core import prfg_pkg::*; #(
   parameter int unsigned QUEUE_ENTRIES = QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_restart,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_data_byte,
   output logic                     rsp_plane_index,
   output logic [PLANE_BYTES_W-1:0] rsp_plane_bytes,
   output logic [STRIDE_W-1:0]      rsp_line_stride,
   output logic                     rsp_last_in_plane,
   output logic                     rsp_last_in_frame,
   output logic [WORD_W-1:0]        rsp_frame_number,
   output logic [WORD_W-1:0]        rsp_stamp_seconds,
   output logic [PERIOD_W-1:0]      rsp_stamp_nanoseconds,
   output logic                     rsp_status
);

   layout_type layout;
   logic       push_valid;
   logic       push_ready;
   logic       push_restart;
   logic       pop_valid;
   logic       pop_ready;
   logic       pop_restart;

   // registers, layout decode, input stage
   prfg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_restart     (push_restart),
      .layout           (layout)
   );

   // decoupling queue
   prfg_queue #(
      .DEPTH (QUEUE_ENTRIES)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_restart (push_restart),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_restart  (pop_restart)
   );

   // generator and result register
   prfg_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .layout                (layout),
      .pop_valid             (pop_valid),
      .pop_ready             (pop_ready),
      .pop_restart           (pop_restart),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_data_byte         (rsp_data_byte),
      .rsp_plane_index       (rsp_plane_index),
      .rsp_plane_bytes       (rsp_plane_bytes),
      .rsp_line_stride       (rsp_line_stride),
      .rsp_last_in_plane     (rsp_last_in_plane),
      .rsp_last_in_frame     (rsp_last_in_frame),
      .rsp_frame_number      (rsp_frame_number),
      .rsp_stamp_seconds     (rsp_stamp_seconds),
      .rsp_stamp_nanoseconds (rsp_stamp_nanoseconds),
      .rsp_status            (rsp_status)
   );

endmodule

/* tb/pseudo_random_frame_generator_core_test.sv */
// Self-checking testbench for the pseudo-random frame generator core: directed table, then
// random register settings and restarts, checked against table or local frame predictor.
// Depends on prfg_pkg and pseudo_random_frame_generator_core.
module pseudo_random_frame_generator_core_test;
   import prfg_pkg::*;

   localparam int unsigned TOTAL_ITEMS   = 1450;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned QUIET_LIMIT   = 3000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned MAX_GAP       = 13;

   typedef struct packed {
      logic [7:0]               data_byte;
      logic                     plane_index;
      logic [PLANE_BYTES_W-1:0] plane_bytes;
      logic [STRIDE_W-1:0]      line_stride;
      logic                     last_in_plane;
      logic                     last_in_frame;
      logic [WORD_W-1:0]        frame_number;
      logic [WORD_W-1:0]        stamp_seconds;
      logic [PERIOD_W-1:0]      stamp_nanoseconds;
      logic                     status;
   } frame_byte_type;

   typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   data;
      logic                    restart;
      logic                    typed;
      frame_byte_type          result;
   } plan_row_type;

   // block ports
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_write_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_restart = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [7:0]               rsp_data_byte;
   logic                     rsp_plane_index;
   logic [PLANE_BYTES_W-1:0] rsp_plane_bytes;
   logic [STRIDE_W-1:0]      rsp_line_stride;
   logic                     rsp_last_in_plane;
   logic                     rsp_last_in_frame;
   logic [WORD_W-1:0]        rsp_frame_number;
   logic [WORD_W-1:0]        rsp_stamp_seconds;
   logic [PERIOD_W-1:0]      rsp_stamp_nanoseconds;
   logic                     rsp_status;

   // predictor copy of the registers
   logic [DIM_W-1:0]    cfg_width  = RESET_WIDTH;
   logic [DIM_W-1:0]    cfg_height = RESET_HEIGHT;
   logic [FORMAT_W-1:0] cfg_format = RESET_FORMAT;
   logic                cfg_multi  = 1'b0;
   logic [WORD_W-1:0]   cfg_seed   = '0;
   logic [PERIOD_W-1:0] cfg_period = RESET_PERIOD;

   // predictor copy of the frame state
   logic [WORD_W-1:0]   lcg_state    = '0;
   int unsigned         byte_offset  = 0;
   int unsigned         plane_sel    = 0;
   logic [WORD_W-1:0]   frame_count  = '0;
   logic [WORD_W-1:0]   stamp_sec    = '0;
   logic [PERIOD_W-1:0] stamp_ns     = '0;
   logic                in_frame     = 1'b0;

   frame_byte_type expected_bytes[$];
   plan_row_type   plan[$];
   int unsigned items_sent = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;
   bit          sender_idle_on = 1'b1;
   bit          receiver_idle_on = 1'b1;
   bit          long_hold_pending = 1'b0;

   pseudo_random_frame_generator_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_restart           (req_restart),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_data_byte         (rsp_data_byte),
      .rsp_plane_index       (rsp_plane_index),
      .rsp_plane_bytes       (rsp_plane_bytes),
      .rsp_line_stride       (rsp_line_stride),
      .rsp_last_in_plane     (rsp_last_in_plane),
      .rsp_last_in_frame     (rsp_last_in_frame),
      .rsp_frame_number      (rsp_frame_number),
      .rsp_stamp_seconds     (rsp_stamp_seconds),
      .rsp_stamp_nanoseconds (rsp_stamp_nanoseconds),
      .rsp_status            (rsp_status)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // out-of-range dimensions are pulled into 1..MAX_DIMENSION
   function automatic int unsigned dim_clamp(input logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIMENSION) return MAX_DIMENSION;
      return 32'(v);
   endfunction

   // plane count, length and stride for the current registers; 0 when unsupported
   function automatic bit plane_layout(input int unsigned pl, output int unsigned count,
                                       output int unsigned len, output int unsigned stride);
      int unsigned w;
      int unsigned p;
      w = dim_clamp(cfg_width);
      p = w * dim_clamp(cfg_height);
      count = 1;
      len = 0;
      stride = 0;
      if (cfg_multi && cfg_format != FMT_NV12) return 1'b0;
      case (cfg_format)
         FMT_MJPEG, FMT_H264: begin
            len = (p / 8 > 32'(MIN_COMPRESSED_BYTES)) ? p / 8 : 32'(MIN_COMPRESSED_BYTES);
         end
         FMT_YUYV, FMT_UYVY: begin
            len = 2 * p;
            stride = 2 * w;
         end
         FMT_RGB24, FMT_BGR24: begin
            len = 3 * p;
            stride = 3 * w;
         end
         FMT_NV12: begin
            stride = w;
            if (cfg_multi) begin
               count = 2;
               len = (pl == 0) ? p : (p + 1) / 2;
            end else begin
               len = p + (p + 1) / 2;
            end
         end
         FMT_GREY: begin
            len = p;
            stride = w;
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // next output byte and frame bookkeeping for one request
   function automatic frame_byte_type predict_frame_byte(input logic restart);
      frame_byte_type r;
      int unsigned count;
      int unsigned len;
      int unsigned stride;
      bit last_plane;
      bit last_frame;
      longint unsigned sum;
      r = '0;
      if (restart) begin
         frame_count = '0;
         stamp_sec = '0;
         stamp_ns = '0;
         in_frame = 1'b0;
      end
      r.frame_number = frame_count;
      r.stamp_seconds = stamp_sec;
      r.stamp_nanoseconds = stamp_ns;
      if (!plane_layout(0, count, len, stride)) begin
         in_frame = 1'b0;
         r.status = 1'b1;
         return r;
      end
      // frame start reloads the generator
      if (!in_frame) begin
         lcg_state = cfg_seed ^ frame_count;
         byte_offset = 0;
         plane_sel = 0;
         in_frame = 1'b1;
      end
      if (plane_sel >= count) plane_sel = 0;
      void'(plane_layout(plane_sel, count, len, stride));
      lcg_state = lcg_state * LCG_MULT + LCG_INC;
      last_plane = (byte_offset + 1) >= len;
      last_frame = last_plane && (plane_sel + 1) >= count;
      r.data_byte = lcg_state[31:24];
      r.plane_index = plane_sel[0];
      r.plane_bytes = len[PLANE_BYTES_W-1:0];
      r.line_stride = stride[STRIDE_W-1:0];
      r.last_in_plane = last_plane;
      r.last_in_frame = last_frame;
      // frame end advances sequence and timestamp
      if (last_frame) begin
         in_frame = 1'b0;
         byte_offset = 0;
         plane_sel = 0;
         frame_count = frame_count + 1;
         sum = 64'(stamp_ns) + 64'(cfg_period);
         stamp_sec = stamp_sec + WORD_W'(sum / NS_PER_SECOND);
         stamp_ns = PERIOD_W'(sum % NS_PER_SECOND);
      end else if (last_plane) begin
         plane_sel = plane_sel + 1;
         byte_offset = 0;
      end else begin
         byte_offset = (byte_offset + 1) & 32'h0FFF_FFFF;
      end
      return r;
   endfunction

   function automatic frame_byte_type typed_byte(input logic [7:0] b,
                                                 input logic [PLANE_BYTES_W-1:0] len,
                                                 input logic [STRIDE_W-1:0] stride,
                                                 input logic lp, input logic lf,
                                                 input logic st);
      frame_byte_type r;
      r = '0;
      r.data_byte = b;
      r.plane_bytes = len;
      r.line_stride = stride;
      r.last_in_plane = lp;
      r.last_in_frame = lf;
      r.status = st;
      return r;
   endfunction

   function automatic void plan_write(input logic [CSR_INDEX_W-1:0] index,
                                      input logic [CSR_DATA_W-1:0] data);
      plan_row_type row;
      row = '0;
      row.kind = ROW_WRITE;
      row.index = index;
      row.data = data;
      plan.insert(plan.size(), row);
   endfunction

   function automatic void plan_item(input logic restart, input logic typed,
                                     input frame_byte_type result);
      plan_row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.restart = restart;
      row.typed = typed;
      row.result = result;
      plan.insert(plan.size(), row);
   endfunction

   // register write, mirrored into the predictor
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_FRAME_WIDTH:  cfg_width = data[DIM_W-1:0];
         CSR_FRAME_HEIGHT: cfg_height = data[DIM_W-1:0];
         CSR_PIXEL_FORMAT: cfg_format = data[FORMAT_W-1:0];
         CSR_MULTI_PLANE:  cfg_multi = data[0];
         CSR_SEED:         cfg_seed = data;
         CSR_PERIOD_NS:    cfg_period = data[PERIOD_W-1:0];
         default: ;
      endcase
   endtask

   // one request transfer; the prediction is queued at the accepting edge
   task automatic send_item(input logic restart, input logic typed,
                            input frame_byte_type result);
      int unsigned gap;
      frame_byte_type predicted;
      gap = sender_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      predicted = predict_frame_byte(restart);
      expected_bytes.insert(expected_bytes.size(), typed ? result : predicted);
      items_sent++;
   endtask

   // block goes idle: every expected byte back, then a settling wait for the pipeline
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [DIM_W-1:0] draw_dimension();
      case ($urandom_range(0, 39))
         0: return '0;
         1: return DIM_W'($urandom_range(0, 16383));
         2: return DIM_W'(MAX_DIMENSION);
         default: return DIM_W'($urandom_range(1, 6));
      endcase
   endfunction

   task automatic check_field(input string field, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_transfer();
      frame_byte_type want;
      if (expected_bytes.size() == 0) begin
         $error("rsp transfer with no expected byte pending");
         mismatch_count++;
         return;
      end
      want = expected_bytes.pop_front();
      check_field("data_byte", want.data_byte, rsp_data_byte);
      check_field("plane_index", want.plane_index, rsp_plane_index);
      check_field("plane_bytes", want.plane_bytes, rsp_plane_bytes);
      check_field("line_stride", want.line_stride, rsp_line_stride);
      check_field("last_in_plane", want.last_in_plane, rsp_last_in_plane);
      check_field("last_in_frame", want.last_in_frame, rsp_last_in_frame);
      check_field("frame_number", want.frame_number, rsp_frame_number);
      check_field("stamp_seconds", want.stamp_seconds, rsp_stamp_seconds);
      check_field("stamp_nanoseconds", want.stamp_nanoseconds, rsp_stamp_nanoseconds);
      check_field("status", want.status, rsp_status);
   endtask

   // receiver: random stalls, one long hold on request
   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_transfer();
      end
   end

   // watchdog on cycles without any transfer or write
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin
      bit writing;
      int unsigned phase;
      int unsigned count;
      logic [FORMAT_W-1:0] fmt;
      logic [CSR_DATA_W-1:0] period;

      // directed table
      plan_item(1'b0, 1'b1, typed_byte(8'd60, 28'd307200, 15'd640, 1'b0, 1'b0, 1'b0));
      plan_item(1'b1, 1'b1, typed_byte(8'd60, 28'd307200, 15'd640, 1'b0, 1'b0, 1'b0));
      // unknown format codes and multi-plane with a non-nv12 format
      plan_write(CSR_PIXEL_FORMAT, 32'd8);
      plan_item(1'b0, 1'b1, typed_byte(8'd0, 28'd0, 15'd0, 1'b0, 1'b0, 1'b1));
      plan_write(CSR_PIXEL_FORMAT, 32'd15);
      plan_item(1'b0, 1'b1, typed_byte(8'd0, 28'd0, 15'd0, 1'b0, 1'b0, 1'b1));
      plan_write(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_GREY));
      plan_write(CSR_MULTI_PLANE, 32'd1);
      plan_item(1'b0, 1'b1, typed_byte(8'd0, 28'd0, 15'd0, 1'b0, 1'b0, 1'b1));
      // largest frame, then dimensions above the limit
      plan_write(CSR_MULTI_PLANE, 32'd0);
      plan_write(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_RGB24));
      plan_write(CSR_FRAME_WIDTH, MAX_DIMENSION);
      plan_write(CSR_FRAME_HEIGHT, MAX_DIMENSION);
      plan_item(1'b0, 1'b1, typed_byte(8'd60, 28'd201326592, 15'd24576, 1'b0, 1'b0, 1'b0));
      plan_write(CSR_FRAME_WIDTH, 32'd16383);
      plan_write(CSR_FRAME_HEIGHT, 32'd16383);
      plan_item(1'b0, 1'b0, '0);
      // zero dimensions, compressed minimum length, restart mid-frame
      plan_write(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_MJPEG));
      plan_write(CSR_FRAME_WIDTH, 32'd0);
      plan_write(CSR_FRAME_HEIGHT, 32'd0);
      plan_item(1'b0, 1'b0, '0);
      plan_item(1'b1, 1'b1, typed_byte(8'd60, 28'd64, 15'd0, 1'b0, 1'b0, 1'b0));
      // plane shrinks under the byte position, then one-byte frames
      plan_write(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_GREY));
      plan_item(1'b0, 1'b0, '0);
      plan_item(1'b0, 1'b0, '0);
      // zero period, then the largest period
      plan_write(CSR_PERIOD_NS, 32'd0);
      plan_item(1'b0, 1'b0, '0);
      plan_item(1'b0, 1'b0, '0);
      plan_write(CSR_PERIOD_NS, 32'h3FFF_FFFF);
      plan_item(1'b0, 1'b0, '0);
      plan_item(1'b0, 1'b0, '0);
      // two-plane nv12, then chroma plane removed while pending
      plan_write(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_NV12));
      plan_write(CSR_MULTI_PLANE, 32'd1);
      plan_write(CSR_SEED, 32'hFFFF_FFFF);
      plan_item(1'b0, 1'b0, '0);
      plan_item(1'b0, 1'b0, '0);
      plan_item(1'b0, 1'b0, '0);
      plan_write(CSR_MULTI_PLANE, 32'd0);
      plan_item(1'b0, 1'b0, '0);
      // remaining formats
      plan_write(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_YUYV));
      plan_item(1'b0, 1'b0, '0);
      plan_write(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_UYVY));
      plan_item(1'b0, 1'b0, '0);
      plan_write(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_BGR24));
      plan_item(1'b0, 1'b0, '0);
      plan_write(CSR_PIXEL_FORMAT, CSR_DATA_W'(FMT_H264));
      plan_item(1'b0, 1'b0, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      writing = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            if (!writing) drain_results();
            writing = 1'b1;
            write_reg(plan[i].index, plan[i].data);
         end else begin
            writing = 1'b0;
            send_item(plan[i].restart, plan[i].typed, plan[i].result);
         end
      end

      // random phases: new settings, then a stream of mostly well-formed frames
      phase = 0;
      while (items_sent < TOTAL_ITEMS) begin
         drain_results();
         write_reg(CSR_FRAME_WIDTH, CSR_DATA_W'(draw_dimension()));
         write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'(draw_dimension()));
         fmt = ($urandom_range(0, 19) == 0) ? FORMAT_W'($urandom_range(8, 15))
                                            : FORMAT_W'($urandom_range(0, 7));
         write_reg(CSR_PIXEL_FORMAT, CSR_DATA_W'(fmt));
         if (phase == 0 || $urandom_range(0, 1)) begin
            if (fmt == FMT_NV12) write_reg(CSR_MULTI_PLANE, $urandom_range(0, 1));
            else write_reg(CSR_MULTI_PLANE, CSR_DATA_W'($urandom_range(0, 19) == 0));
         end
         if (phase == 0 || $urandom_range(0, 1)) write_reg(CSR_SEED, $urandom);
         if (phase == 0 || $urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
               0: period = 0;
               1: period = 32'h3FFF_FFFF;
               2: period = $urandom & 32'h3FFF_FFFF;
               default: period = $urandom_range(1, 1000000000);
            endcase
            write_reg(CSR_PERIOD_NS, period);
         end
         sender_idle_on = ($urandom_range(0, 2) != 0);
         receiver_idle_on = ($urandom_range(0, 2) != 0);
         // back-pressure: receiver holds off while requests keep coming
         if (phase == 4) begin
            sender_idle_on = 1'b0;
            long_hold_pending = 1'b1;
         end
         count = $urandom_range(10, 60);
         repeat (count) send_item($urandom_range(0, 31) == 0, 1'b0, '0);
         phase++;
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
